// ----- hw/rtl/drrip_pkg.sv -----
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared widths, codes and control types of the DRRIP replacement block.
// ----------------------------------------------------------------------------
package drrip_pkg;

  localparam int unsigned SetIdxW  = 11;
  localparam int unsigned WayIdxW  = 4;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned BucketW  = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned LfsrW    = 16;
  localparam int unsigned ConfW    = 2;
  localparam int unsigned PickW    = 5;

  typedef logic [1:0] rrpv_t;

  localparam rrpv_t RrpvNear = 2'd0;
  localparam rrpv_t RrpvLong = 2'd2;
  localparam rrpv_t RrpvMax  = 2'd3;

  // operation codes
  localparam logic OpVictim = 1'b0;
  localparam logic OpUpdate = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSrripBucket = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBrripBucket = 1'd1;

  localparam logic [BucketW-1:0] SrripBucketRst = 6'd0;
  localparam logic [BucketW-1:0] BrripBucketRst = 6'd32;

  localparam logic [LfsrW-1:0] LfsrSeed = 16'd1;
  localparam logic [ConfW-1:0] ConfRst  = 2'd2;
  localparam logic [ConfW-1:0] ConfTop  = 2'd3;

  typedef struct packed {
    logic srrip;
    logic brrip;
  } lead_t;

  typedef struct packed {
    logic  hit_en;
    logic  fill_en;
    lead_t lead;
  } pol_ctl_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] stride;
  } strm_upd_t;

endpackage

// ----- hw/rtl/drrip_if.sv -----
// ----------------------------------------------------------------------------
// drrip_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface drrip_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [drrip_pkg::SetIdxW-1:0]  set_index;
  logic [drrip_pkg::WayIdxW-1:0]  way_index;
  logic [drrip_pkg::AddrW-1:0]    address;
  logic                           was_hit;

  modport source (
    output valid, operation, set_index, way_index, address, was_hit,
    input  ready
  );
  modport sink (
    input  valid, operation, set_index, way_index, address, was_hit,
    output ready
  );
endinterface

interface drrip_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [drrip_pkg::WayIdxW-1:0]  victim_way;
  logic                           streaming;

  modport source (
    output valid, victim_way, streaming,
    input  ready
  );
  modport sink (
    input  valid, victim_way, streaming,
    output ready
  );
endinterface

// ----- hw/rtl/drrip_rrpv_mem.sv -----
// ----------------------------------------------------------------------------
// drrip_rrpv_mem
// Per-set RRPV row store: one read port with registered data, one write
// port, and a sweep after reset that fills every row with the maximum RRPV.
// ----------------------------------------------------------------------------
module drrip_rrpv_mem #(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [$clog2(NUM_SETS)-1:0]        rd_set_i,
  output logic [NUM_WAYS-1:0][1:0]           rd_row_o,
  input  logic                               wr_en_i,
  input  logic [$clog2(NUM_SETS)-1:0]        wr_set_i,
  input  logic [NUM_WAYS-1:0][1:0]           wr_row_i,
  output logic                               clr_busy_o
);

  localparam int unsigned SetW = $clog2(NUM_SETS);

  logic [NUM_WAYS-1:0][1:0] rrpv_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][1:0] rd_row_q;
  logic [SetW-1:0]          clr_cnt_q, clr_cnt_d;
  logic                     clr_busy_q, clr_busy_d;
  logic                     mem_we;
  logic [SetW-1:0]          mem_waddr;
  logic [NUM_WAYS-1:0][1:0] mem_wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + SetW'(1);
      if (clr_cnt_q == SetW'(NUM_SETS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // all ones: every way at the maximum RRPV
  assign mem_we    = clr_busy_q || wr_en_i;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : wr_set_i;
  assign mem_wdata = clr_busy_q ? '1 : wr_row_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rrpv_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_row_q <= rrpv_mem[rd_set_i];
    end
  end

  assign rd_row_o   = rd_row_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ----- hw/rtl/drrip_stream_det.sv -----
// ----------------------------------------------------------------------------
// drrip_stream_det
// Stride-stream detector: absolute stride against the last miss address and
// a 2-bit confidence that falls on repeated nonzero strides.
// ----------------------------------------------------------------------------
module drrip_stream_det (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [drrip_pkg::AddrW-1:0]   addr_i,
  input  drrip_pkg::strm_upd_t          upd_i,
  output logic [drrip_pkg::AddrW-1:0]   stride_o,
  output logic                          streaming_o
);

  logic [drrip_pkg::AddrW-1:0] last_addr_q;
  logic [drrip_pkg::AddrW-1:0] last_stride_q;
  logic [drrip_pkg::ConfW-1:0] conf_q, conf_d;
  logic [drrip_pkg::AddrW-1:0] eff_last;
  logic                        stride_match;

  // take the address of a miss committing this cycle ahead of the register
  always_comb begin
    eff_last = upd_i.en ? upd_i.addr : last_addr_q;
    stride_o = (addr_i >= eff_last) ? (addr_i - eff_last) : (eff_last - addr_i);
  end

  always_comb begin
    stride_match = (upd_i.stride == last_stride_q) && (upd_i.stride != '0);
    conf_d       = conf_q;
    if (stride_match) begin
      if (conf_q != '0) begin
        conf_d = conf_q - drrip_pkg::ConfW'(1);
      end
    end else if (conf_q != drrip_pkg::ConfTop) begin
      conf_d = conf_q + drrip_pkg::ConfW'(1);
    end
    streaming_o = !conf_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_addr_q   <= '0;
      last_stride_q <= '0;
      conf_q        <= drrip_pkg::ConfRst;
    end else if (upd_i.en) begin
      last_addr_q   <= upd_i.addr;
      last_stride_q <= upd_i.stride;
      conf_q        <= conf_d;
    end
  end

endmodule

// ----- hw/rtl/drrip_ins_policy.sv -----
// ----------------------------------------------------------------------------
// drrip_ins_policy
// Set dueling counter and BRRIP random source; picks the insertion RRPV of
// a non-streaming fill.
// ----------------------------------------------------------------------------
module drrip_ins_policy #(
  parameter int unsigned DUEL_MAX = 1023
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drrip_pkg::pol_ctl_t   ctl_i,
  output drrip_pkg::rrpv_t      ins_o
);

  localparam int unsigned DuelW = $clog2(DUEL_MAX + 1);
  localparam logic [DuelW-1:0] DuelTop  = DuelW'(DUEL_MAX);
  localparam logic [DuelW-1:0] DuelHalf = DuelW'(DUEL_MAX / 2);

  logic [DuelW-1:0]              duel_q;
  logic [drrip_pkg::LfsrW-1:0]   lfsr_q, lfsr_d;
  logic                          use_brrip;
  logic                          fb;

  always_comb begin
    use_brrip = ctl_i.lead.brrip || (!ctl_i.lead.srrip && !(duel_q > DuelHalf));
    fb        = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    lfsr_d    = {fb, lfsr_q[drrip_pkg::LfsrW-1:1]};
    if (!use_brrip || (lfsr_d[drrip_pkg::PickW-1:0] == '0)) begin
      ins_o = drrip_pkg::RrpvLong;
    end else begin
      ins_o = drrip_pkg::RrpvMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duel_q <= DuelHalf;
      lfsr_q <= drrip_pkg::LfsrSeed;
    end else begin
      // advance the LFSR once per BRRIP insertion
      if (ctl_i.fill_en && use_brrip) begin
        lfsr_q <= lfsr_d;
      end
      if (ctl_i.hit_en) begin
        if (ctl_i.lead.srrip && (duel_q != DuelTop)) begin
          duel_q <= duel_q + DuelW'(1);
        end else if (ctl_i.lead.brrip && (duel_q != '0)) begin
          duel_q <= duel_q - DuelW'(1);
        end
      end
    end
  end

endmodule

// ----- hw/rtl/drrip_replacement_with_stream_bypass.sv -----
// ----------------------------------------------------------------------------
// drrip_replacement_with_stream_bypass
// DRRIP replacement policy with 2-bit RRPVs, set dueling and stream bypass.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one word per lookup: operation 0 asks for a victim way of
//   set_index, operation 1 reports a hit (was_hit 1) or a miss fill of
//   way_index. rsp_o returns one word per request: victim_way for a victim
//   request, streaming set for a miss fill judged part of a stream.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the SRRIP and BRRIP leader buckets;
//   write them only while no request is in flight.
// Timing:
//   A request accepted into the modify stage has its set row read from the
//   RRPV memory as it is accepted; the row is modified and written back
//   when the request leaves the modify stage, where the result word is
//   loaded into the output register. One request per cycle is sustained
//   while rsp_o is not stalled, since each request takes one row read and
//   one row write on separate memory ports (back-to-back requests on one
//   set take the row from the write-back bypass).
// Reset and stall:
//   After reset the row memory is swept to the maximum RRPV, one set per
//   cycle until all NUM_SETS rows are written; req_i.ready stays low
//   meanwhile. When rsp_o is stalled one result waits in the output register
//   and one more request is held in the modify stage; then req_i.ready drops.
// ----------------------------------------------------------------------------
module drrip_replacement_with_stream_bypass #(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned DUEL_MAX = 1023
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  drrip_req_if.sink                          req_i,
  drrip_rsp_if.source                        rsp_o,
  input  logic                               cfg_we_i,
  input  logic [drrip_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [drrip_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned SetW = $clog2(NUM_SETS);
  localparam int unsigned ExtW = (SetW > drrip_pkg::SetIdxW) ? SetW : drrip_pkg::SetIdxW;
  localparam int unsigned WayW = $clog2(NUM_WAYS);

  // configuration
  logic [drrip_pkg::BucketW-1:0] srrip_bucket_q, brrip_bucket_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srrip_bucket_q <= drrip_pkg::SrripBucketRst;
      brrip_bucket_q <= drrip_pkg::BrripBucketRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        drrip_pkg::CfgSrripBucket: srrip_bucket_q <= cfg_data_i;
        drrip_pkg::CfgBrripBucket: brrip_bucket_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request side
  logic                          req_acc;
  logic [ExtW-1:0]               req_set_ext;
  logic [SetW-1:0]               req_set;
  logic                          clr_busy;
  logic [drrip_pkg::AddrW-1:0]   req_stride;

  // modify stage
  logic                          b_valid_q;
  logic                          b_fire;
  logic                          b_op_q;
  logic [SetW-1:0]               b_set_q;
  logic [drrip_pkg::WayIdxW-1:0] b_way_q;
  logic [drrip_pkg::AddrW-1:0]   b_addr_q;
  logic                          b_hit_q;
  logic [drrip_pkg::AddrW-1:0]   b_stride_q;

  // write-back bypass
  logic                          fwd_valid_q;
  logic [SetW-1:0]               fwd_set_q;
  logic [NUM_WAYS-1:0][1:0]      fwd_row_q;

  // output register
  logic                          out_valid_q;
  logic [drrip_pkg::WayIdxW-1:0] out_victim_q;
  logic                          out_stream_q;

  logic [NUM_WAYS-1:0][1:0]      rd_row;
  logic [NUM_WAYS-1:0][1:0]      row_cur;
  logic [NUM_WAYS-1:0][1:0]      row_aged;
  logic [NUM_WAYS-1:0][1:0]      row_upd;
  logic [NUM_WAYS-1:0][1:0]      row_new;
  logic [NUM_WAYS-1:0]           hi_bits, lo_bits;
  drrip_pkg::rrpv_t              top_rrpv, age, ins_rrpv, upd_rrpv;
  logic [WayW-1:0]               victim;
  logic                          streaming;
  logic                          is_miss;
  logic [drrip_pkg::BucketW-1:0] bucket;
  drrip_pkg::lead_t              lead;
  drrip_pkg::pol_ctl_t           pol_ctl;
  drrip_pkg::strm_upd_t          strm_upd;

  assign req_set_ext   = ExtW'(req_i.set_index);
  assign req_set       = req_set_ext[SetW-1:0];
  assign b_fire        = b_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready   = !clr_busy && (!b_valid_q || b_fire);
  assign req_acc       = req_i.valid && req_i.ready;

  drrip_rrpv_mem #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_rrpv_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (req_acc),
    .rd_set_i   (req_set),
    .rd_row_o   (rd_row),
    .wr_en_i    (b_fire),
    .wr_set_i   (b_set_q),
    .wr_row_i   (row_new),
    .clr_busy_o (clr_busy)
  );

  assign is_miss         = (b_op_q == drrip_pkg::OpUpdate) && !b_hit_q;
  assign strm_upd.en     = b_fire && is_miss;
  assign strm_upd.addr   = b_addr_q;
  assign strm_upd.stride = b_stride_q;

  drrip_stream_det u_stream_det (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .addr_i      (req_i.address),
    .upd_i       (strm_upd),
    .stride_o    (req_stride),
    .streaming_o (streaming)
  );

  assign bucket     = b_set_q[drrip_pkg::BucketW-1:0];
  assign lead.srrip = (bucket == srrip_bucket_q);
  assign lead.brrip = !lead.srrip && (bucket == brrip_bucket_q);

  assign pol_ctl.hit_en  = b_fire && (b_op_q == drrip_pkg::OpUpdate) && b_hit_q;
  assign pol_ctl.fill_en = b_fire && is_miss && !streaming;
  assign pol_ctl.lead    = lead;

  drrip_ins_policy #(
    .DUEL_MAX (DUEL_MAX)
  ) u_ins_policy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pol_ctl),
    .ins_o  (ins_rrpv)
  );

  // stage register: hold the request while its row is modified and written back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (req_acc) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      b_op_q     <= req_i.operation;
      b_set_q    <= req_set;
      b_way_q    <= req_i.way_index;
      b_addr_q   <= req_i.address;
      b_hit_q    <= req_i.was_hit;
      b_stride_q <= req_stride;
    end
  end

  // the last row written is the newest copy of its set
  assign row_cur = (fwd_valid_q && (fwd_set_q == b_set_q)) ? fwd_row_q : rd_row;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hi_bits[w] = row_cur[w][1];
      lo_bits[w] = row_cur[w][0];
    end
    top_rrpv[1] = |hi_bits;
    top_rrpv[0] = top_rrpv[1] ? |(hi_bits & lo_bits) : |lo_bits;
    age         = drrip_pkg::RrpvMax - top_rrpv;
    victim      = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_cur[w] == top_rrpv) begin
        victim = WayW'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_aged[w] = row_cur[w] + age;
    end
  end

  always_comb begin
    if (b_hit_q) begin
      upd_rrpv = drrip_pkg::RrpvNear;
    end else if (streaming) begin
      upd_rrpv = drrip_pkg::RrpvMax;
    end else begin
      upd_rrpv = ins_rrpv;
    end
    // a way beyond NUM_WAYS matches nothing and leaves the row as read
    row_upd = row_cur;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (6'(b_way_q) == 6'(w)) begin
        row_upd[w] = upd_rrpv;
      end
    end
    row_new = (b_op_q == drrip_pkg::OpVictim) ? row_aged : row_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (b_fire) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      fwd_set_q <= b_set_q;
      fwd_row_q <= row_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_victim_q <= (b_op_q == drrip_pkg::OpVictim) ? drrip_pkg::WayIdxW'(victim) : '0;
      out_stream_q <= is_miss && streaming;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.victim_way = out_victim_q;
  assign rsp_o.streaming  = out_stream_q;

  a_acc_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> b_valid_q)
    else $error("accepted request did not reach the modify stage");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> out_valid_q)
    else $error("finished request did not load the output register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !b_fire)
    else $error("stalled result word overwritten");

  a_no_acc_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (!b_valid_q && !out_valid_q))
    else $error("request in flight during the memory sweep");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_stream_q && (out_victim_q != '0)))
    else $error("result word has both a victim and a streaming flag");

endmodule
